// ===== rtl/bffr_pkg.sv =====
// Package for the binary frame filter receiver.
// Holds constants, the controller state type and the command/status structs.
// No dependencies.
package bffr_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int FILL_W      = ADDR_W + 1;
  localparam int ID_POS      = 4;

  localparam int DATA_W      = 8;
  localparam int MAXLEN_W    = 7;
  localparam int LEN_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [DATA_W-1:0] START_FIRST  = 8'hA0;
  localparam logic [DATA_W-1:0] START_SECOND = 8'hA1;
  localparam logic [DATA_W-1:0] END_FIRST    = 8'h0D;
  localparam logic [DATA_W-1:0] END_SECOND   = 8'h0A;

  localparam logic [CFG_IDX_W-1:0] CFG_REQ_ID  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_SOS1,
    ST_SOS2,
    ST_LENH,
    ST_LENL,
    ST_BODY,
    ST_EOS1,
    ST_EOS2,
    ST_READ,
    ST_SHOW
  } state_e;

  typedef struct packed {
    logic frame_open;
    logic store;
    logic clear_fill;
    logic load_len_hi;
    logic load_len_lo;
    logic dec_len;
    logic xor_acc;
    logic rd_start;
    logic rd_en;
    logic rd_next;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start1;
    logic is_start2;
    logic is_end1;
    logic is_end2;
    logic xor_match;
    logic full;
    logic cap_zero;
    logic payload_zero;
    logic id_match;
    logic rd_last;
  } dp_status_t;

endpackage

// ===== rtl/bffr_datapath.sv =====
// Datapath of the frame receiver: config registers, length/checksum/fill
// registers, the frame store memory and the replay read path.
// Depends on bffr_pkg.
module bffr_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bffr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bffr_pkg::DATA_W-1:0]      cfg_wdata_i,
  input  logic [bffr_pkg::DATA_W-1:0]      rx_byte_i,
  input  bffr_pkg::dp_cmd_t                cmd_i,
  output bffr_pkg::dp_status_t             status_o,
  output logic [bffr_pkg::DATA_W-1:0]      frame_byte_o,
  output logic [bffr_pkg::ADDR_W-1:0]      byte_index_o
);
  import bffr_pkg::*;

  logic [DATA_W-1:0]   req_id_q;
  logic [MAXLEN_W-1:0] max_len_q;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [DATA_W-1:0]   xor_q, xor_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [DATA_W-1:0]   id_q;
  logic [ADDR_W-1:0]   rd_k_q, rd_k_d;
  logic [DATA_W-1:0]   rd_data_q;
  logic [DATA_W-1:0]   mem [FRAME_BYTES];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_id_q  <= '0;
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REQ_ID:  req_id_q  <= cfg_wdata_i;
        CFG_MAX_LEN: max_len_q <= cfg_wdata_i[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear_fill) begin
      fill_d = '0;
    end else if (cmd_i.frame_open) begin
      fill_d = FILL_W'(1);
    end else if (cmd_i.store) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_comb begin
    xor_d = xor_q;
    if (cmd_i.frame_open) begin
      xor_d = '0;
    end else if (cmd_i.xor_acc) begin
      xor_d = xor_q ^ rx_byte_i;
    end
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.load_len_hi) begin
      len_d = {rx_byte_i, 8'h00};
    end else if (cmd_i.load_len_lo) begin
      len_d = {len_q[LEN_W-1:8], rx_byte_i};
    end else if (cmd_i.dec_len) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  always_comb begin
    rd_k_d = rd_k_q;
    if (cmd_i.rd_start) begin
      rd_k_d = '0;
    end else if (cmd_i.rd_next) begin
      rd_k_d = rd_k_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      xor_q  <= '0;
      len_q  <= '0;
      rd_k_q <= '0;
    end else begin
      fill_q <= fill_d;
      xor_q  <= xor_d;
      len_q  <= len_d;
      rd_k_q <= rd_k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && fill_q == FILL_W'(ID_POS)) begin
      id_q <= rx_byte_i;
    end
  end

  assign mem_we    = cmd_i.frame_open || (cmd_i.store && !fill_q[FILL_W-1]);
  assign mem_waddr = cmd_i.frame_open ? '0 : fill_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_k_q];
    end
  end

  always_comb begin
    status_o.is_start1    = (rx_byte_i == START_FIRST);
    status_o.is_start2    = (rx_byte_i == START_SECOND);
    status_o.is_end1      = (rx_byte_i == END_FIRST);
    status_o.is_end2      = (rx_byte_i == END_SECOND);
    status_o.xor_match    = (rx_byte_i == xor_q);
    status_o.full         = (32'(fill_q) >= 32'(max_len_q)) ||
                            (32'(fill_q) >= 32'(FRAME_BYTES));
    status_o.cap_zero     = (max_len_q == '0);
    status_o.payload_zero = (len_q == '0);
    status_o.id_match     = (id_q == req_id_q);
    status_o.rd_last      = ((FILL_W'(rd_k_q) + FILL_W'(1)) == fill_q);
  end

  assign frame_byte_o = rd_data_q;
  assign byte_index_o = rd_k_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(FRAME_BYTES))
    else $error("fill count beyond frame store");

  a_rd_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (FILL_W'(rd_k_q) < fill_q))
    else $error("replay read past stored frame");

endmodule

// ===== rtl/bffr_ctrl.sv =====
// Controller of the frame receiver: parse phase state machine plus the
// replay sequence. Drives datapath commands and the channel handshakes.
// Depends on bffr_pkg.
module bffr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  bffr_pkg::dp_status_t status_i,
  output bffr_pkg::dp_cmd_t    cmd_o
);
  import bffr_pkg::*;

  state_e state_q, state_d;
  logic   in_xfer;
  logic   retry;
  logic   can_open;

  assign in_stall_o  = (state_q == ST_READ) || (state_q == ST_SHOW);
  assign out_valid_o = (state_q == ST_SHOW);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign can_open    = status_i.is_start1 && !status_i.cap_zero;

  // byte falls back to start-of-frame check
  always_comb begin
    retry = 1'b0;
    if (in_xfer) begin
      unique case (state_q) inside
        ST_SOS1: retry = 1'b1;
        ST_SOS2: retry = status_i.full || !status_i.is_start2;
        ST_LENH, ST_LENL: retry = status_i.full;
        ST_BODY: retry = status_i.full ||
                         (status_i.payload_zero && !status_i.xor_match);
        ST_EOS1: retry = status_i.full || !status_i.is_end1;
        ST_EOS2: retry = status_i.full || !status_i.is_end2;
        default: retry = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_READ: state_d = ST_SHOW;
      ST_SHOW: begin
        if (!out_stall_i) begin
          state_d = status_i.rd_last ? ST_SOS1 : ST_READ;
        end
      end
      default: begin
        if (retry) begin
          state_d = can_open ? ST_SOS2 : ST_SOS1;
        end else if (in_xfer) begin
          unique case (state_q)
            ST_SOS2: state_d = ST_LENH;
            ST_LENH: state_d = ST_LENL;
            ST_LENL: state_d = ST_BODY;
            ST_BODY: state_d = status_i.payload_zero ? ST_EOS1 : ST_BODY;
            ST_EOS1: state_d = ST_EOS2;
            ST_EOS2: state_d = status_i.id_match ? ST_READ : ST_SOS1;
            default: state_d = ST_SOS1;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_SHOW: begin
        if (!out_stall_i) begin
          if (status_i.rd_last) begin
            cmd_o.clear_fill = 1'b1;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        if (retry) begin
          if (can_open) begin
            cmd_o.frame_open = 1'b1;
          end else begin
            cmd_o.clear_fill = 1'b1;
          end
        end else if (in_xfer) begin
          unique case (state_q)
            ST_LENH: begin
              cmd_o.store       = 1'b1;
              cmd_o.load_len_hi = 1'b1;
            end
            ST_LENL: begin
              cmd_o.store       = 1'b1;
              cmd_o.load_len_lo = 1'b1;
            end
            ST_BODY: begin
              cmd_o.store = 1'b1;
              if (!status_i.payload_zero) begin
                cmd_o.xor_acc = 1'b1;
                cmd_o.dec_len = 1'b1;
              end
            end
            ST_EOS2: begin
              if (status_i.id_match) begin
                cmd_o.store    = 1'b1;
                cmd_o.rd_start = 1'b1;
              end else begin
                cmd_o.clear_fill = 1'b1;
              end
            end
            default: cmd_o.store = 1'b1;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SOS1;
    end else begin
      state_q <= state_d;
    end
  end

  a_fill_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.frame_open, cmd_o.store, cmd_o.clear_fill}))
    else $error("conflicting fill commands");

  a_store_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> !status_i.full)
    else $error("store into full frame");

  a_show_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHOW && out_stall_i) |=> (state_q == ST_SHOW))
    else $error("result dropped while stalled");

endmodule

// ===== rtl/binary_frame_filter_receiver_unit.sv =====
// Top level of the binary frame filter receiver.
// Instantiates bffr_ctrl and bffr_datapath; depends on bffr_pkg.
//
// Takes one received byte per cycle while parsing frames of the form
// A0 A1 LEN_HI LEN_LO payload XOR 0D 0A, holding each frame in a 64-byte
// store. A bad start, checksum or end byte, or a frame longer than
// max_frame_len (or 64 bytes), drops the frame and the byte is rechecked as
// a start byte in the same cycle. When a frame ends and its byte at index 4
// equals requested_id, input stalls and the frame is replayed from the
// store, each byte by a registered memory read and then an output
// transfer that waits while the output is stalled; byte_index counts from
// 0 and last_byte marks the final byte. No clearing pass after reset.
// Configuration: index 0 is requested_id, index 1 is max_frame_len.
module binary_frame_filter_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bffr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bffr_pkg::DATA_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bffr_pkg::DATA_W-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bffr_pkg::DATA_W-1:0]    frame_byte_o,
  output logic [bffr_pkg::ADDR_W-1:0]    byte_index_o,
  output logic                           last_byte_o
);
  import bffr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bffr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bffr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o)
  );

  assign last_byte_o = status.rd_last;

endmodule

// ===== bench/binary_frame_filter_receiver_unit_tb.sv =====
// Testbench for binary_frame_filter_receiver_unit: random frames, broken frames and noise
// go in, and a scoreboard class predicts every delivered byte and checks it.
// Depends on bffr_pkg and the binary_frame_filter_receiver_unit RTL.
module binary_frame_filter_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bffr_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] index;
    logic              last;
  } frame_beat_t;

  typedef logic [DATA_W-1:0] byte_q_t[$];

  typedef enum int {
    FLAW_NONE,
    FLAW_SOS2,
    FLAW_XOR,
    FLAW_EOS1,
    FLAW_EOS2,
    FLAW_LONG_LEN
  } flaw_e;

  class frame_scoreboard;
    logic [DATA_W-1:0]   req_id;
    logic [MAXLEN_W-1:0] max_len;
    state_e              phase;
    logic [LEN_W-1:0]    left;
    logic [DATA_W-1:0]   xsum;
    logic [FILL_W-1:0]   fill;
    logic [DATA_W-1:0]   store [FRAME_BYTES];
    frame_beat_t         expected_q[$];
    int                  errors;

    function new();
      req_id  = '0;
      max_len = MAX_LEN_RESET;
      phase   = ST_SOS1;
      left    = '0;
      xsum    = '0;
      fill    = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx == CFG_REQ_ID) req_id = val;
      else max_len = val[MAXLEN_W-1:0];
    endfunction

    function int cap();
      return (max_len > FRAME_BYTES) ? FRAME_BYTES : int'(max_len);
    endfunction

    function void push_byte(logic [DATA_W-1:0] b);
      if (fill < FRAME_BYTES) store[fill[ADDR_W-1:0]] = b;
      fill = fill + 1'b1;
    endfunction

    function void abandon();
      phase = ST_SOS1;
      fill  = '0;
    endfunction

    function void deliver();
      int n;
      frame_beat_t e;
      n = (fill > FRAME_BYTES) ? FRAME_BYTES : int'(fill);
      for (int k = 0; k < n; k++) begin
        e.data  = store[k];
        e.index = k[ADDR_W-1:0];
        e.last  = (k == n - 1);
        expected_q.push_back(e);
      end
    endfunction

    // returns 1 when the byte has to be looked at again as a start byte
    function bit parse(logic [DATA_W-1:0] b);
      if (phase != ST_SOS1 && fill >= cap()) begin
        abandon();
        return 1'b1;
      end
      case (phase)
        ST_SOS2: begin
          if (b != START_SECOND) begin
            abandon();
            return 1'b1;
          end
          push_byte(b);
          left  = '0;
          phase = ST_LENH;
        end
        ST_LENH: begin
          push_byte(b);
          left  = {b, 8'h00};
          phase = ST_LENL;
        end
        ST_LENL: begin
          push_byte(b);
          left  = left | {8'h00, b};
          phase = ST_BODY;
        end
        ST_BODY: begin
          if (left != 0) begin
            push_byte(b);
            xsum = xsum ^ b;
            left = left - 1'b1;
          end else if (b != xsum) begin
            abandon();
            return 1'b1;
          end else begin
            push_byte(b);
            phase = ST_EOS1;
          end
        end
        ST_EOS1: begin
          if (b != END_FIRST) begin
            abandon();
            return 1'b1;
          end
          push_byte(b);
          phase = ST_EOS2;
        end
        ST_EOS2: begin
          if (b != END_SECOND) begin
            abandon();
            return 1'b1;
          end
          push_byte(b);
          if (fill > ID_POS && store[ID_POS] == req_id) deliver();
          abandon();
        end
        default: begin
          abandon();
          if (b == START_FIRST && cap() > 0) begin
            push_byte(b);
            xsum  = '0;
            phase = ST_SOS2;
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void note_rx(logic [DATA_W-1:0] b);
      if (parse(b)) void'(parse(b));
    endfunction

    function void check_out(logic [DATA_W-1:0] d, logic [ADDR_W-1:0] i, logic l);
      frame_beat_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte %02h index %0d last %0b", $time, d, i, l);
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.data) begin
        errors++;
        $display("%0t: frame_byte expected %02h, got %02h", $time, e.data, d);
      end
      if (i !== e.index) begin
        errors++;
        $display("%0t: byte_index expected %0d, got %0d", $time, e.index, i);
      end
      if (l !== e.last) begin
        errors++;
        $display("%0t: last_byte expected %0b, got %0b", $time, e.last, l);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [DATA_W-1:0]    rx_byte_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DATA_W-1:0]    frame_byte_o;
  logic [ADDR_W-1:0]    byte_index_o;
  logic                 last_byte_o;

  bit              idle_on    = 1'b1;
  int              stall_left = 0;
  frame_scoreboard sb         = new();

  binary_frame_filter_receiver_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .last_byte_o  (last_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_rx(rx_byte_i);
      if (out_valid_o && !out_stall_i) sb.check_out(frame_byte_o, byte_index_o, last_byte_o);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 11);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [DATA_W-1:0] spoil(logic [DATA_W-1:0] good);
    if ($urandom_range(0, 1) == 0) return START_FIRST;
    return good ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic byte_q_t make_frame(logic [DATA_W-1:0] id, int len, flaw_e flaw);
    byte_q_t           q;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] p;
    x = '0;
    q.push_back(START_FIRST);
    q.push_back((flaw == FLAW_SOS2) ? spoil(START_SECOND) : START_SECOND);
    if (flaw == FLAW_LONG_LEN) begin
      q.push_back(8'($urandom_range(1, 255)));
      q.push_back(8'($urandom));
      repeat (70) q.push_back(8'($urandom));
      return q;
    end
    q.push_back(8'(len >> 8));
    q.push_back(8'(len));
    for (int k = 0; k < len; k++) begin
      p = (k == 0) ? id : 8'($urandom);
      x = x ^ p;
      q.push_back(p);
    end
    q.push_back((flaw == FLAW_XOR) ? spoil(x) : x);
    q.push_back((flaw == FLAW_EOS1) ? spoil(END_FIRST) : END_FIRST);
    q.push_back((flaw == FLAW_EOS2) ? spoil(END_SECOND) : END_SECOND);
    return q;
  endfunction

  task automatic send_bytes(input byte_q_t q);
    int gap;
    foreach (q[k]) begin
      @(negedge clk_i);
      in_valid_i <= 1'b1;
      rx_byte_i  <= q[k];
      do @(posedge clk_i); while (in_stall_o);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        rx_byte_i  <= 8'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] req, input logic [DATA_W-1:0] len_wdata,
                           input int budget);
    int      sent;
    int      c;
    int      maxp;
    int      len;
    int      r;
    byte_q_t q;
    write_cfg(CFG_REQ_ID, req);
    write_cfg(CFG_MAX_LEN, len_wdata);
    c    = (len_wdata[MAXLEN_W-1:0] > FRAME_BYTES) ? FRAME_BYTES : int'(len_wdata[MAXLEN_W-1:0]);
    maxp = c - 7;
    sent = 0;
    while (sent < budget) begin
      r   = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? maxp : $urandom_range(0, (maxp < 12) ? maxp : 12);
      if (r < 55) q = make_frame(req, len, FLAW_NONE);
      else if (r < 70) q = make_frame(8'($urandom), len, FLAW_NONE);
      else if (r < 82) q = make_frame(req, len, flaw_e'($urandom_range(FLAW_SOS2, FLAW_EOS2)));
      else if (r < 88) q = make_frame(req, len, FLAW_LONG_LEN);
      else if (r < 94) q = make_frame(req, maxp + 1, FLAW_NONE);
      else begin
        q.delete();
        repeat ($urandom_range(1, 6))
          q.push_back(($urandom_range(0, 3) == 0) ? START_FIRST : 8'($urandom));
      end
      send_bytes(q);
      sent += q.size();
    end
    drain();
  endtask

  initial begin
    byte_q_t q;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // repeated first start byte, then an empty payload delivered for id 0
    q = '{START_FIRST, START_FIRST, START_SECOND, 8'h00, 8'h00, 8'h00, END_FIRST, END_SECOND};
    send_bytes(q);
    drain();

    // id FF delivered; then a bad checksum that opens a new frame, which is skipped
    write_cfg(CFG_REQ_ID, 8'hFF);
    q = '{START_FIRST, START_SECOND, 8'h00, 8'h01, 8'hFF, 8'hFF, END_FIRST, END_SECOND,
          START_FIRST, START_SECOND, 8'h00, 8'h01, 8'hFF,
          START_FIRST, START_SECOND, 8'h00, 8'h00, 8'h00, END_FIRST, END_SECOND};
    send_bytes(q);
    drain();

    run_phase(8'($urandom), 8'd64, 35);
    run_phase(8'h00, 8'd7, 35);
    run_phase(8'hFF, 8'hC0, 35);
    run_phase(8'($urandom), {1'($urandom), 7'($urandom_range(7, 64))}, 35);
    run_phase(8'($urandom), {1'($urandom), 7'($urandom_range(7, 64))}, 35);
    idle_on = 1'b0;
    run_phase(8'($urandom), 8'd64, 35);

    repeat (16) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%0t: %0d expected output bytes never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== binary_frame_filter_receiver_unit.f =====
rtl/bffr_pkg.sv
rtl/bffr_datapath.sv
rtl/bffr_ctrl.sv
rtl/binary_frame_filter_receiver_unit.sv
bench/binary_frame_filter_receiver_unit_tb.sv
